[rtl/pu_pkg.sv]
// ----------------------------------------------------------------------------
// Permutation unrank package
// Shared widths, types and register codes for the permutation unranking
// pipeline.
// ----------------------------------------------------------------------------
package pu_pkg;

    // Design sizes
    localparam int MAX_ELEMENTS = 8;
    localparam int ELEMENT_BITS = 8;
    localparam int LIST_BITS    = MAX_ELEMENTS * ELEMENT_BITS;
    localparam int RANK_BITS    = 16;
    localparam int SIZE_BITS    = 4;
    localparam int DIGIT_BITS   = $clog2(MAX_ELEMENTS);
    localparam int CNT_BITS     = $clog2(MAX_ELEMENTS + 1);
    localparam int SIZE_RESET   = 8;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SET_SIZE     = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SET_ELEMENTS = 1'd1;

    // Element list, element zero in the lowest slot
    typedef logic [MAX_ELEMENTS-1:0][ELEMENT_BITS-1:0] elem_list_t;

    // Factorial-base digits, digit k in slot k
    typedef logic [MAX_ELEMENTS-1:0][DIGIT_BITS-1:0] digit_vec_t;

    // Payload of the digit extraction chain
    typedef struct packed {
        logic [RANK_BITS-1:0] quot;
        digit_vec_t           digits;
    } pu_digit_t;

    // Payload of the element selection chain
    typedef struct packed {
        elem_list_t elems;
        digit_vec_t digits;
    } pu_sel_t;

endpackage

[rtl/pu_digit_cell.sv]
// ----------------------------------------------------------------------------
// Factorial digit cell
// Divides the running quotient by a fixed small divisor using a reciprocal
// multiply and one correction step, and stores the remainder as a digit.
// ----------------------------------------------------------------------------
module pu_digit_cell
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [pu_pkg::CNT_BITS-1:0]          divisor,
    input  logic [pu_pkg::RANK_BITS-1:0]         recip,
    input  logic [pu_pkg::DIGIT_BITS-1:0]        digit_pos,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  pu_pkg::pu_digit_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output pu_pkg::pu_digit_t                    out_data
);
    import pu_pkg::*;

    logic                     valid_a_reg;
    logic                     valid_b_reg;
    logic                     ready_a;
    logic                     ready_b;
    logic [RANK_BITS-1:0]     x_a_reg;
    logic [2*RANK_BITS-1:0]   prod_a_reg;
    logic [2*RANK_BITS-1:0]   prod_next;
    digit_vec_t               digits_a_reg;
    logic [RANK_BITS-1:0]     q_est;
    logic [RANK_BITS-1:0]     back;
    logic [RANK_BITS-1:0]     rem_est;
    logic [RANK_BITS-1:0]     div_w;
    logic                     over;
    pu_digit_t                data_b_next;
    pu_digit_t                data_b_reg;

    // Each stage moves on when it is empty or its successor takes a transfer.
    assign ready_b  = !valid_b_reg || out_ready;
    assign ready_a  = !valid_a_reg || ready_b;
    assign in_ready = ready_a;

    // Stage A: estimate of the quotient by reciprocal multiply.
    assign prod_next = (2*RANK_BITS)'(in_data.quot) * (2*RANK_BITS)'(recip);

    // Stage B: remainder of the estimate, then one correction.
    always_comb
    begin
        div_w   = RANK_BITS'(divisor);
        q_est   = prod_a_reg[2*RANK_BITS-1:RANK_BITS];
        back    = RANK_BITS'(q_est * div_w);
        rem_est = x_a_reg - back;
        over    = (rem_est >= div_w);
        data_b_next        = '{quot: q_est, digits: digits_a_reg};
        if (over)
        begin
            data_b_next.quot = q_est + RANK_BITS'(1);
            rem_est          = rem_est - div_w;
        end
        data_b_next.digits[digit_pos] = rem_est[DIGIT_BITS-1:0];
    end

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                valid_a_reg <= in_valid;
            end
            if (ready_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            x_a_reg      <= in_data.quot;
            prod_a_reg   <= prod_next;
            digits_a_reg <= in_data.digits;
        end
        if (ready_b && valid_a_reg)
        begin
            data_b_reg <= data_b_next;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_data  = data_b_reg;

endmodule

[rtl/pu_select_cell.sv]
// ----------------------------------------------------------------------------
// Element selection cell
// Settles one position of the permutation: the element at the digit's offset
// among the remaining elements moves to this position, the ones it passes
// shift up by one.
// ----------------------------------------------------------------------------
module pu_select_cell
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [pu_pkg::DIGIT_BITS-1:0]        pos,
    input  logic [pu_pkg::CNT_BITS-1:0]          list_size,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  pu_pkg::pu_sel_t                      in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output pu_pkg::pu_sel_t                      out_data
);
    import pu_pkg::*;

    logic                   valid_reg;
    pu_sel_t                data_reg;
    pu_sel_t                data_next;
    elem_list_t             prev;
    logic [CNT_BITS-1:0]    pos_w;
    logic [CNT_BITS-1:0]    k;
    logic [CNT_BITS-1:0]    top;
    logic [DIGIT_BITS-1:0]  digit;
    logic                   active;

    assign in_ready = !valid_reg || out_ready;

    // Each slot's lower neighbour, for the shift-up.
    always_comb
    begin
        prev[0] = in_data.elems[0];
        for (int j = 1; j < MAX_ELEMENTS; j++)
        begin
            prev[j] = in_data.elems[j-1];
        end
    end

    // Pick the digit for this position and rotate the chosen element down.
    always_comb
    begin
        pos_w  = CNT_BITS'(pos);
        active = ((pos_w + CNT_BITS'(1)) < list_size);
        k      = list_size - CNT_BITS'(1) - pos_w;
        digit  = active ? in_data.digits[k[DIGIT_BITS-1:0]] : '0;
        top    = pos_w + CNT_BITS'(digit);
        data_next = in_data;
        for (int j = 0; j < MAX_ELEMENTS; j++)
        begin
            if (CNT_BITS'(j) == pos_w)
            begin
                data_next.elems[j] = in_data.elems[top[DIGIT_BITS-1:0]];
            end
            else if ((CNT_BITS'(j) > pos_w) && (CNT_BITS'(j) <= top))
            begin
                data_next.elems[j] = prev[j];
            end
        end
    end

    // Stage valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/permutation_unrank.sv]
// ----------------------------------------------------------------------------
// Permutation unrank
// Returns the lexicographic permutation of a given rank over a configured
// list of up to eight elements.
// ----------------------------------------------------------------------------
// Pipeline: two stages per digit cell (multiply, then correct), one per select
// cell, one output stage.
// Throughput: one rank per cycle unless out_ready stalls; every stage is fully pipelined.
// Reset: pipeline empty, list length eight, all list elements zero.
// ----------------------------------------------------------------------------
module permutation_unrank
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [pu_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [pu_pkg::LIST_BITS-1:0]         cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [pu_pkg::RANK_BITS-1:0]         rank,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [pu_pkg::LIST_BITS-1:0]         permuted_elements
);
    import pu_pkg::*;

    logic [SIZE_BITS-1:0]     set_size_reg;
    logic [LIST_BITS-1:0]     set_elements_reg;
    logic [CNT_BITS-1:0]      list_size;

    logic [MAX_ELEMENTS-1:0]  dc_valid;
    logic [MAX_ELEMENTS-1:0]  dc_ready;
    pu_digit_t                dc_data [MAX_ELEMENTS];

    logic [MAX_ELEMENTS-1:0]  sc_valid;
    logic [MAX_ELEMENTS-1:0]  sc_ready;
    pu_sel_t                  sc_data [MAX_ELEMENTS];

    logic                     out_valid_reg;
    logic                     out_take;
    elem_list_t               out_next;
    elem_list_t               out_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_size_reg     <= SIZE_BITS'(SIZE_RESET);
            set_elements_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SET_SIZE:     set_size_reg     <= cfg_data[SIZE_BITS-1:0];
                CFG_SET_ELEMENTS: set_elements_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // List length, saturated at the maximum.
    assign list_size = (set_size_reg > SIZE_BITS'(MAX_ELEMENTS))
                     ? CNT_BITS'(MAX_ELEMENTS) : CNT_BITS'(set_size_reg);

    // Entry of the digit chain
    assign dc_valid[0] = in_valid;
    assign in_ready    = dc_ready[0];
    assign dc_data[0]  = '{quot: rank, digits: '0};

    // Digit chain: cell k divides by k+1 and keeps digit k.
    for (genvar k = 1; k < MAX_ELEMENTS; k++)
    begin : g_digit
        localparam int DIV   = k + 1;
        localparam int RECIP = (2 ** RANK_BITS) / DIV;

        pu_digit_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .divisor   (CNT_BITS'(DIV)),
            .recip     (RANK_BITS'(RECIP)),
            .digit_pos (DIGIT_BITS'(k)),
            .in_valid  (dc_valid[k-1]),
            .in_ready  (dc_ready[k-1]),
            .in_data   (dc_data[k-1]),
            .out_valid (dc_valid[k]),
            .out_ready (dc_ready[k]),
            .out_data  (dc_data[k])
        );
    end

    // Hand-over from digits to selection: load the configured list.
    assign sc_valid[0]              = dc_valid[MAX_ELEMENTS-1];
    assign dc_ready[MAX_ELEMENTS-1] = sc_ready[0];
    assign sc_data[0] = '{elems:  elem_list_t'(set_elements_reg),
                          digits: dc_data[MAX_ELEMENTS-1].digits};

    // Selection chain: cell i settles position i.
    for (genvar i = 0; i < MAX_ELEMENTS - 1; i++)
    begin : g_select
        pu_select_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .pos       (DIGIT_BITS'(i)),
            .list_size (list_size),
            .in_valid  (sc_valid[i]),
            .in_ready  (sc_ready[i]),
            .in_data   (sc_data[i]),
            .out_valid (sc_valid[i+1]),
            .out_ready (sc_ready[i+1]),
            .out_data  (sc_data[i+1])
        );
    end

    // Output stage: clear the slots beyond the list length.
    assign out_take                 = !out_valid_reg || out_ready;
    assign sc_ready[MAX_ELEMENTS-1] = out_take;

    always_comb
    begin
        for (int j = 0; j < MAX_ELEMENTS; j++)
        begin
            out_next[j] = (CNT_BITS'(j) < list_size)
                        ? sc_data[MAX_ELEMENTS-1].elems[j] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg <= sc_valid[MAX_ELEMENTS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take && sc_valid[MAX_ELEMENTS-1])
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign permuted_elements = out_reg;

endmodule

[dv/permutation_unrank_tb.sv]
// ----------------------------------------------------------------------------
// Permutation unrank testbench
// Writes list lengths and element lists through the configuration port,
// sends ranks over the input channel and checks every returned permutation
// against a predictor kept in the testbench. Both channels idle and stall at
// random, with some stretches run at full rate.
// ----------------------------------------------------------------------------
module permutation_unrank_tb;

    import pu_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int TRAIL_CYCLES = 30;
    localparam int PHASE_COUNT  = 23;
    localparam int PHASE_ITEMS  = 60;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_SET_SIZE;
    logic [LIST_BITS-1:0]      cfg_data  = '0;
    logic                      in_valid  = 1'b0;
    logic                      in_ready;
    logic [RANK_BITS-1:0]      rank      = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [LIST_BITS-1:0]      permuted_elements;

    // Testbench copy of the configuration registers
    logic [SIZE_BITS-1:0]      model_size = SIZE_BITS'(SIZE_RESET);
    logic [LIST_BITS-1:0]      model_list = '0;

    // Permutations still to come, oldest first
    logic [LIST_BITS-1:0]      expected_perms[$];
    logic [LIST_BITS-1:0]      want;

    bit                        idle_on       = 1'b1;
    int                        mismatches    = 0;
    int                        ranks_sent    = 0;
    int                        settings_seen = 0;
    int                        quiet_cycles  = 0;

    permutation_unrank dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .rank              (rank),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .permuted_elements (permuted_elements)
    );

    always #10 clk = ~clk;

    // Factorial of a small count.
    function automatic int unsigned factorial(input int k);
        int unsigned f;
        f = 1;
        for (int t = 2; t <= k; t++)
            f = f * t;
        return f;
    endfunction

    // Permutation of the given rank over the first entries of the list.
    function automatic logic [LIST_BITS-1:0] unrank_list(input logic [SIZE_BITS-1:0] size,
                                                         input logic [LIST_BITS-1:0] list,
                                                         input logic [RANK_BITS-1:0] r);
        elem_list_t       slots;
        elem_list_t       src;
        int               n;
        int               d;
        int unsigned      rem;
        logic [ELEMENT_BITS-1:0] picked;
        slots = '0;
        src   = list;
        n     = (int'(size) > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(size);
        if (n == 0)
            return '0;
        for (int i = 0; i < n; i++)
            slots[i] = src[i];
        rem = int'(r) % factorial(n);
        // Pull the chosen element to the front of the remaining list.
        for (int i = 0; i + 1 < n; i++)
        begin
            d      = (rem / factorial(n - 1 - i)) % (n - i);
            picked = slots[i + d];
            for (int j = i + d; j > i; j--)
                slots[j] = slots[j - 1];
            slots[i] = picked;
        end
        return slots;
    endfunction

    // Rank drawn to favour the useful range, with some wrapped values.
    function automatic logic [RANK_BITS-1:0] pick_rank(input logic [SIZE_BITS-1:0] size);
        int                   n;
        int unsigned          span;
        logic [RANK_BITS-1:0] r;
        n    = (int'(size) > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(size);
        span = factorial(n);
        case ($urandom_range(0, 3))
            0, 1:    r = RANK_BITS'($urandom_range(0, span - 1));
            2:       r = RANK_BITS'($urandom_range(0, 16'hFFFF));
            default: r = RANK_BITS'(span * $urandom_range(1, 65535 / span)
                                    + $urandom_range(0, span - 1));
        endcase
        return r;
    endfunction

    // Write both registers on consecutive edges; the pipeline must be empty.
    task automatic write_config(input logic [LIST_BITS-1:0] size_word,
                                input logic [LIST_BITS-1:0] list);
        cfg_write <= 1'b1;
        cfg_index <= CFG_SET_SIZE;
        cfg_data  <= size_word;
        @(posedge clk);
        cfg_index <= CFG_SET_ELEMENTS;
        cfg_data  <= list;
        @(posedge clk);
        cfg_write  <= 1'b0;
        model_size  = size_word[SIZE_BITS-1:0];
        model_list  = list;
        settings_seen++;
    endtask

    // Send one rank and record its permutation once the transfer happens.
    task automatic send_rank(input logic [RANK_BITS-1:0] r);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rank     <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_perms.push_back(unrank_list(model_size, model_list, r));
        ranks_sent++;
    endtask

    // Hold the input channel until every outstanding permutation has arrived.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_perms.size() != 0)
            @(posedge clk);
    endtask

    // The register values straight after reset.
    task automatic test_reset_values();
        send_rank(16'd0);
        send_rank(16'd40319);
        send_rank(16'hFFFF);
        wait_drained();
    endtask

    // Eight distinct elements: first, last, wrapped and top ranks.
    task automatic test_full_list_extremes();
        write_config({60'h0, 4'd8}, 64'h0706_0504_0302_0100);
        send_rank(16'd0);
        send_rank(16'd1);
        send_rank(16'd5040);
        send_rank(16'd40319);
        send_rank(16'd40320);
        send_rank(16'hFFFF);
        wait_drained();
    endtask

    // Lists of one and two elements, and the empty list.
    task automatic test_short_lists();
        write_config({60'hFFF_FFFF_FFFF_FFFF, 4'd1}, 64'hFFFF_FFFF_FFFF_FF80);
        send_rank(16'd0);
        send_rank(16'hFFFF);
        wait_drained();
        write_config({60'h0, 4'd2}, 64'h1234_5678_9ABC_A55A);
        send_rank(16'd0);
        send_rank(16'd1);
        send_rank(16'd2);
        wait_drained();
        write_config({60'hA5A_5A5A_5A5A_5A5A, 4'd0}, 64'hFFFF_FFFF_FFFF_FFFF);
        send_rank(16'd7);
        send_rank(16'hFFFF);
        wait_drained();
    endtask

    // Lengths above eight are taken as eight.
    task automatic test_size_saturation();
        write_config({60'h0, 4'd15}, 64'h8877_6655_4433_2211);
        send_rank(16'd0);
        send_rank(16'd12345);
        send_rank(16'hFFFF);
        wait_drained();
        write_config({60'h0, 4'd9}, 64'hF0E0_D0C0_B0A0_9080);
        send_rank(16'd40320);
        wait_drained();
    endtask

    // A full-rate burst, a pause until the pipeline has drained, then more.
    task automatic test_drain_pause();
        write_config({60'h0, 4'd8}, {$urandom, $urandom});
        idle_on = 1'b0;
        repeat (40) send_rank(pick_rank(model_size));
        wait_drained();
        idle_on = 1'b1;
        repeat (40) send_rank(pick_rank(model_size));
        wait_drained();
    endtask

    // Random list settings, each followed by a run of random ranks.
    task automatic test_random_settings();
        logic [LIST_BITS-1:0] size_word;
        logic [LIST_BITS-1:0] list;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            size_word = {$urandom, $urandom};
            case (phase)
                0:       size_word[SIZE_BITS-1:0] = 4'd8;
                1:       size_word[SIZE_BITS-1:0] = 4'd1;
                2:       size_word[SIZE_BITS-1:0] = 4'd0;
                3:       size_word[SIZE_BITS-1:0] = 4'd15;
                default:
                begin
                    case ($urandom_range(0, 9))
                        0:       size_word[SIZE_BITS-1:0] = 4'd0;
                        1:       size_word[SIZE_BITS-1:0] = SIZE_BITS'($urandom_range(9, 15));
                        default: size_word[SIZE_BITS-1:0] = SIZE_BITS'($urandom_range(1, 8));
                    endcase
                end
            endcase
            case ($urandom_range(0, 7))
                0:       list = '1;
                1:       list = '0;
                2:       list = {8{8'($urandom)}};
                default: list = {$urandom, $urandom};
            endcase
            write_config(size_word, list);
            // Every fourth setting runs with no idling on either side.
            idle_on = (phase % 4) != 3;
            repeat (PHASE_ITEMS) send_rank(pick_rank(model_size));
            wait_drained();
        end
        idle_on = 1'b1;
    endtask

    // Result sink: random stalls on the output channel.
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            stall = idle_on ? $urandom_range(0, 8) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // Compare each output transfer with the oldest expected permutation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_perms.size() == 0)
            begin
                $display("%0t: permuted_elements expected none, actual %h",
                         $time, permuted_elements);
                mismatches++;
            end
            else
            begin
                want = expected_perms.pop_front();
                if (permuted_elements !== want)
                begin
                    $display("%0t: permuted_elements expected %h, actual %h",
                             $time, want, permuted_elements);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too long without a transfer on either channel ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("permutation_unrank verification failed");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_full_list_extremes();
        test_short_lists();
        test_size_saturation();
        test_drain_pause();
        test_random_settings();
        wait_drained();
        repeat (TRAIL_CYCLES) @(posedge clk);
        $display("Checked %0d ranks over %0d list settings, list lengths 0 to 15,",
                 ranks_sent, settings_seen + 1);
        $display("with wrapped ranks, saturated lengths and random stalls on both channels.");
        if (mismatches == 0)
            $display("permutation_unrank verification clean");
        else
            $display("permutation_unrank verification failed");
        $finish;
    end

endmodule
